// ===== sv/background_frame_accumulator_macros.svh =====
// Assertion helpers for the background frame accumulator.
`ifndef BACKGROUND_FRAME_ACCUMULATOR_MACROS_SVH
`define BACKGROUND_FRAME_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/bfa_pkg.sv =====
`default_nettype none
package bfa_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned BINS     = 256;
  localparam logic [7:0]  GREY_MAX = 8'd255;

  localparam logic [1:0] METHOD_MEAN = 2'd0;
  localparam logic [1:0] METHOD_MODE = 2'd1;
  localparam logic [1:0] METHOD_MAX  = 2'd2;
  localparam logic [1:0] METHOD_MIN  = 2'd3;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    RES_ACC,
    RES_DIRECT,
    RES_MEAN,
    RES_MODE
  } res_sel_e;

  typedef struct packed {
    logic     accept;
    logic     clr;
    logic     exec_acc;
    logic     div_start;
    logic     div_step;
    logic     scan_start;
    logic     scan_issue;
    logic     finish;
    logic     fin_hold;
    res_sel_e res_sel;
  } bfa_cmd_t;

  typedef struct packed {
    logic op_rd;
    logic in_range;
    logic frames_zero;
    logic div_last;
    logic scan_last;
    logic clr_last;
    logic out_free;
  } bfa_st_t;

endpackage
`default_nettype wire

// ===== sv/bfa_ctrl.sv =====
`default_nettype none
module bfa_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      method_i,
  input  wire bfa_pkg::bfa_st_t st_i,
  output bfa_pkg::bfa_cmd_t    cmd_o
);
  import bfa_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_MFIN  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_SDRN  = 4'd6;
  localparam logic [3:0] S_XFIN  = 4'd7;
  localparam logic [3:0] S_HOLD  = 4'd8;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_ACC;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (st_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!st_i.op_rd) begin
          cmd_o.exec_acc = 1'b1;
          cmd_o.finish   = 1'b1;
          cmd_o.res_sel  = RES_ACC;
          state_d = st_i.out_free ? S_IDLE : S_HOLD;
        end else if (st_i.in_range && method_i == METHOD_MEAN && !st_i.frames_zero) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else if (st_i.in_range && method_i == METHOD_MODE) begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end else begin
          cmd_o.finish  = 1'b1;
          cmd_o.res_sel = RES_DIRECT;
          state_d = st_i.out_free ? S_IDLE : S_HOLD;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) begin
          state_d = S_MFIN;
        end
      end
      S_MFIN: begin
        cmd_o.finish  = 1'b1;
        cmd_o.res_sel = RES_MEAN;
        state_d = st_i.out_free ? S_IDLE : S_HOLD;
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (st_i.scan_last) begin
          state_d = S_SDRN;
        end
      end
      S_SDRN: begin
        state_d = S_XFIN;
      end
      S_XFIN: begin
        cmd_o.finish  = 1'b1;
        cmd_o.res_sel = RES_MODE;
        state_d = st_i.out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        cmd_o.fin_hold = 1'b1;
        if (st_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bfa_dp.sv =====
`default_nettype none
module bfa_dp #(
  parameter int unsigned PIXELS           = 1024,
  parameter int unsigned BIN_COUNT_BITS   = 16,
  parameter int unsigned FRAME_COUNT_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bfa_pkg::bfa_cmd_t cmd_i,
  output bfa_pkg::bfa_st_t       st_o,
  input  wire logic [1:0]        method_i,
  input  wire logic              operation_i,
  input  wire logic [9:0]        pixel_index_i,
  input  wire logic [7:0]        sample_i,
  input  wire logic              frame_end_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             pixel_value_o,
  output logic                   status_o
);
  import bfa_pkg::*;

  localparam int unsigned AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int unsigned HAW    = AW + SAMPLE_W;
  localparam int unsigned HDEPTH = PIXELS * BINS;
  localparam int unsigned FW     = FRAME_COUNT_BITS;
  localparam int unsigned SW     = SAMPLE_W + FRAME_COUNT_BITS;
  localparam int unsigned BW     = BIN_COUNT_BITS;
  localparam int unsigned CW     = $clog2(SW);

  // request fields
  logic          op_q;
  logic          range_q;
  logic [AW-1:0] idx_q;
  logic [7:0]    sample_q;
  logic          fe_q;
  logic [31:0]   idx_in32;
  logic [AW-1:0] idx_in;

  assign idx_in32 = 32'(pixel_index_i);
  assign idx_in   = idx_in32[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= operation_i;
      range_q  <= idx_in32 < 32'(PIXELS);
      idx_q    <= idx_in;
      sample_q <= sample_i;
      fe_q     <= frame_end_i;
    end
  end

  // frame counter
  logic [FW-1:0] frames_q;
  logic          full, fzero;
  assign full  = frames_q == '1;
  assign fzero = frames_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= '0;
    end else if (cmd_i.exec_acc && !full && fe_q) begin
      frames_q <= frames_q + 1'b1;
    end
  end

  // pixel store
  logic [SW-1:0] store_mem [0:PIXELS-1];
  logic [SW-1:0] store_rd_q;
  logic [SW-1:0] store_wd;
  logic [7:0]    cur;
  logic          store_we;

  assign cur      = store_rd_q[7:0];
  assign store_we = cmd_i.exec_acc && !full && range_q && method_i != METHOD_MODE;

  always_comb begin
    case (method_i)
      METHOD_MEAN: store_wd = fzero ? SW'(sample_q) : store_rd_q + SW'(sample_q);
      METHOD_MAX:  store_wd = (fzero || sample_q > cur) ? SW'(sample_q) : SW'(cur);
      default:     store_wd = (fzero || sample_q < cur) ? SW'(sample_q) : SW'(cur);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[idx_q] <= store_wd;
    end
    if (cmd_i.accept) begin
      store_rd_q <= store_mem[idx_in];
    end
  end

  // histogram store, cleared by a sweep after reset
  logic [BW-1:0]  hist_mem [0:HDEPTH-1];
  logic [BW-1:0]  hist_rd_q;
  logic [HAW-1:0] clr_q;
  logic [7:0]     bin_q;
  logic [HAW-1:0] hrd_addr, hwr_addr;
  logic [BW-1:0]  hwr_data;
  logic           hist_inc, hwe, hre;

  assign hist_inc = cmd_i.exec_acc && !full && range_q && method_i == METHOD_MODE
                    && hist_rd_q != '1;
  assign hwe      = cmd_i.clr || hist_inc;
  assign hwr_addr = cmd_i.clr ? clr_q : {idx_q, sample_q};
  assign hwr_data = cmd_i.clr ? '0 : hist_rd_q + 1'b1;
  assign hre      = cmd_i.accept || cmd_i.scan_issue;
  assign hrd_addr = cmd_i.accept ? {idx_in, sample_i} : {idx_q, bin_q};

  always_ff @(posedge clk_i) begin
    if (hwe) begin
      hist_mem[hwr_addr] <= hwr_data;
    end
    if (hre) begin
      hist_rd_q <= hist_mem[hrd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // mode scan: issue one bin a cycle, compare it in the next cycle
  logic          cmp_v_q;
  logic [7:0]    cmp_bin_q;
  logic [BW-1:0] best_cnt_q;
  logic [7:0]    best_bin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_v_q <= 1'b0;
    end else begin
      cmp_v_q <= cmd_i.scan_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      bin_q <= '0;
    end else if (cmd_i.scan_issue) begin
      bin_q <= bin_q + 1'b1;
    end
    cmp_bin_q <= bin_q;
    if (cmp_v_q && (cmp_bin_q == '0 || hist_rd_q > best_cnt_q)) begin
      best_cnt_q <= hist_rd_q;
      best_bin_q <= cmp_bin_q;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [SW-1:0] quo_q;
  logic [FW-1:0] rem_q;
  logic [CW-1:0] dcnt_q;
  logic [FW:0]   rem_sh, rem_sub;
  logic          ge;

  assign rem_sh  = {rem_q, quo_q[SW-1]};
  assign ge      = rem_sh >= {1'b0, frames_q};
  assign rem_sub = rem_sh - {1'b0, frames_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q  <= store_rd_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[SW-2:0], ge};
      rem_q  <= ge ? rem_sub[FW-1:0] : rem_sh[FW-1:0];
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // round half to even, saturate
  logic [FW:0]   twice_r;
  logic          up;
  logic [SW:0]   qr;
  logic [7:0]    mean_val;

  assign twice_r  = {rem_q, 1'b0};
  assign up       = (twice_r > {1'b0, frames_q})
                    || (twice_r == {1'b0, frames_q} && quo_q[0]);
  assign qr       = {1'b0, quo_q} + (SW + 1)'(up);
  assign mean_val = (qr > (SW + 1)'(GREY_MAX)) ? GREY_MAX : qr[7:0];

  // result and output register
  logic [7:0] res_val;
  logic       res_st;
  logic       out_free, load_out;
  logic [7:0] hold_val_q;
  logic       hold_st_q;

  always_comb begin
    res_val = '0;
    res_st  = 1'b0;
    case (cmd_i.res_sel)
      RES_ACC:    res_st  = full;
      RES_DIRECT: res_val = (range_q && method_i[1]) ? cur : '0;
      RES_MEAN:   res_val = mean_val;
      RES_MODE:   res_val = best_bin_q;
      default:    res_val = '0;
    endcase
  end

  assign out_free = !out_valid_o || out_ready_i;
  assign load_out = (cmd_i.finish || cmd_i.fin_hold) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && !out_free) begin
      hold_val_q <= res_val;
      hold_st_q  <= res_st;
    end
    if (load_out) begin
      pixel_value_o <= cmd_i.fin_hold ? hold_val_q : res_val;
      status_o      <= cmd_i.fin_hold ? hold_st_q : res_st;
    end
  end

  assign st_o.op_rd       = op_q == OP_READ;
  assign st_o.in_range    = range_q;
  assign st_o.frames_zero = fzero;
  assign st_o.div_last    = dcnt_q == CW'(SW - 1);
  assign st_o.scan_last   = bin_q == 8'(BINS - 1);
  assign st_o.clr_last    = clr_q == HAW'(HDEPTH - 1);
  assign st_o.out_free    = out_free;

endmodule
`default_nettype wire

// ===== sv/background_frame_accumulator.sv =====
// Accumulate and direct reads (max, min, out of range, mean with no frames) finish
//   straight from the execute state; a mean read first runs the restoring divider (one
//   quotient bit a cycle); a mode read first scans all 256 bins of the pixel.
// One request at a time: intake reopens once the previous result is in the output register.
// Reset (rst_ni low, async): method 0, frame count 0, then a clearing pass
//   zeroes the histogram memory one counter a cycle; no request is taken
//   meanwhile, configuration writes are.
`default_nettype none
module background_frame_accumulator #(
  parameter int unsigned PIXELS           = 1024,
  parameter int unsigned BIN_COUNT_BITS   = 16,
  parameter int unsigned FRAME_COUNT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB-style configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [9:0]  pixel_index_i,
  input  wire logic [7:0]  sample_i,
  input  wire logic        frame_end_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       pixel_value_o,
  output logic             status_o
);
  import bfa_pkg::*;

  localparam logic [2:0] ADDR_METHOD = 3'd0;

  // method register: 0 mean, 1 mode, 2 max, 3 min
  logic [1:0] method_q;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_METHOD) ? {30'd0, method_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METHOD_MEAN;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_METHOD) begin
      method_q <= pwdata[1:0];
    end
  end

  bfa_cmd_t cmd;
  bfa_st_t  st;

  // sequencer: clearing pass, request intake, divide / scan loops, result hold
  bfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .method_i   (method_q),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // stores, frame counter, divider, mode scan and output register
  bfa_dp #(
    .PIXELS           (PIXELS),
    .BIN_COUNT_BITS   (BIN_COUNT_BITS),
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .method_i      (method_q),
    .operation_i   (operation_i),
    .pixel_index_i (pixel_index_i),
    .sample_i      (sample_i),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .status_o      (status_o)
  );

`include "background_frame_accumulator_macros.svh"

  // no request is taken during the histogram clearing pass
  `BFA_ASSERT_IMPL(a_no_take_in_clear, cmd.clr, !in_ready_o)
  // a flagged accumulate carries a zero value
  `BFA_ASSERT_IMPL(a_status_zero_val, out_valid_o && status_o, pixel_value_o == 8'd0)
  // one request at a time: intake closes right after a take
  `BFA_ASSERT_NEXT(a_single_request, in_valid_i && in_ready_o, !in_ready_o)

endmodule
`default_nettype wire

// ===== verif/tb_background_frame_accumulator.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_background_frame_accumulator;
  import bfa_pkg::*;

  localparam int unsigned NPIX      = 1024;
  localparam int unsigned FRAME_MAX = 65535;  // frame counter full at 2^16-1
  localparam int unsigned BIN_MAX   = 65535;  // histogram counter ceiling
  localparam logic [2:0]  ADDR_METHOD = 3'd0;

  // clock / reset
  logic clk_i;
  logic rst_ni;

  // config port
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // request / result channels
  logic       in_valid_i;
  logic       in_ready_o;
  logic       operation_i;
  logic [9:0] pixel_index_i;
  logic [7:0] sample_i;
  logic       frame_end_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] pixel_value_o;
  logic       status_o;

  background_frame_accumulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .pixel_index_i (pixel_index_i),
    .sample_i      (sample_i),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .status_o      (status_o)
  );

  // One expected result per request.
  typedef struct {
    logic [7:0] pixel;
    logic       status;
  } bg_result_t;

  bg_result_t expected_bg[$];
  bg_result_t got_bg;

  // Shadow of the block's state.
  logic [31:0] shadow_store [NPIX];
  logic [15:0] shadow_bins  [NPIX][256];
  int unsigned frames_cnt;
  logic [1:0]  method_cfg;

  // Store entries known to be written (only these may be read or
  // accumulated under mean/max/min, so no undefined word is ever used).
  int unsigned written_pix[$];

  int unsigned errors;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned full_hits;
  int unsigned mode_reads;
  bit          idle_en;

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop. Covers the histogram clearing pass and all requests with
  // slow mode reads and stalls, several times over.
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $display("timeout: %0d requests sent, %0d results seen, %0d pending",
             requests_sent, results_seen, expected_bg.size());
    $finish;
  end

  task automatic note_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
    errors++;
    if (errors <= 10)
      $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
  endtask

  // Predicts one result and updates the shadow state.
  function automatic void model_background(input logic op, input logic [9:0] idx,
                                            input logic [7:0] smp, input logic fe,
                                            output logic [7:0] val, output logic st);
    longint unsigned q;
    longint unsigned r;
    int unsigned     best;
    val = '0;
    st  = 1'b0;
    if (op == OP_ACC) begin
      if (frames_cnt >= FRAME_MAX) begin
        st = 1'b1;  // counter full: nothing changes
      end else begin
        case (method_cfg)
          METHOD_MEAN: shadow_store[idx] = (frames_cnt == 0) ? 32'(smp)
                                           : shadow_store[idx] + 32'(smp);
          METHOD_MODE: if (shadow_bins[idx][smp] != BIN_MAX[15:0])
                         shadow_bins[idx][smp] = shadow_bins[idx][smp] + 16'd1;
          METHOD_MAX: shadow_store[idx] = (frames_cnt == 0 || smp > shadow_store[idx][7:0])
                                          ? 32'(smp) : 32'(shadow_store[idx][7:0]);
          default: shadow_store[idx] = (frames_cnt == 0 || smp < shadow_store[idx][7:0])
                                       ? 32'(smp) : 32'(shadow_store[idx][7:0]);
        endcase
        if (fe) frames_cnt++;
      end
    end else begin
      case (method_cfg)
        METHOD_MEAN: begin
          if (frames_cnt != 0) begin
            q = shadow_store[idx] / frames_cnt;
            r = shadow_store[idx] % frames_cnt;
            // round half to even
            if (2 * r > frames_cnt || (2 * r == frames_cnt && q[0])) q++;
            val = (q > GREY_MAX) ? GREY_MAX : q[7:0];
          end
        end
        METHOD_MODE: begin
          best = 0;
          for (int b = 1; b < 256; b++)
            if (shadow_bins[idx][b] > shadow_bins[idx][best]) best = b;
          val = best[7:0];
        end
        default: val = shadow_store[idx][7:0];
      endcase
    end
  endfunction

  // Sends one request; optional random gap before raising valid.
  task automatic send_request(input logic op, input logic [9:0] idx,
                              input logic [7:0] smp, input logic fe);
    int unsigned gap;
    bg_result_t  e;
    gap = 0;
    if (idle_en && $urandom_range(99) < 18) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    pixel_index_i <= idx;
    sample_i      <= smp;
    frame_end_i   <= fe;
    do @(posedge clk_i); while (!in_ready_o);
    model_background(op, idx, smp, fe, e.pixel, e.status);
    if (e.status) full_hits++;
    if (op == OP_READ && method_cfg == METHOD_MODE) mode_reads++;
    expected_bg.insert(expected_bg.size(), e);
    requests_sent++;
  endtask

  // Waits until every result is back, then a short settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_bg.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of the method register, then read it back.
  task automatic write_method(input logic [1:0] m);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_METHOD;
    pwdata  <= 32'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    method_cfg = m;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[1:0] !== m) note_mismatch("method readback", m, prdata[1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result checker and receiver-side backpressure.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bg.size() == 0) begin
        note_mismatch("unexpected result, pixel_value", 0, pixel_value_o);
      end else begin
        got_bg = expected_bg.pop_front();
        results_seen++;
        if (pixel_value_o !== got_bg.pixel)
          note_mismatch("pixel_value", got_bg.pixel, pixel_value_o);
        if (status_o !== got_bg.status)
          note_mismatch("status", got_bg.status, status_o);
      end
    end
    out_ready_i <= !idle_en || ($urandom_range(99) >= 18);
  end

  // Extremes of the fields, first-frame direct store, mean with no frames,
  // rounding to even, mode ties, empty histogram, method changes mid-run.
  task automatic test_directed();
    write_method(METHOD_MEAN);
    // first frame: samples stored directly
    send_request(OP_ACC, 10'd0, 8'd0, 1'b0);
    send_request(OP_ACC, 10'd1023, 8'd255, 1'b0);
    send_request(OP_ACC, 10'd5, 8'd128, 1'b0);
    send_request(OP_ACC, 10'd341, 8'd77, 1'b0);
    send_request(OP_ACC, 10'd682, 8'd1, 1'b0);
    send_request(OP_ACC, 10'd100, 8'd254, 1'b0);
    send_request(OP_READ, 10'd0, 8'd0, 1'b0);        // no frames yet -> 0
    send_request(OP_ACC, 10'd777, 8'd128, 1'b1);
    // second frame: sums
    send_request(OP_ACC, 10'd0, 8'd255, 1'b0);
    send_request(OP_ACC, 10'd1023, 8'd255, 1'b0);
    send_request(OP_ACC, 10'd5, 8'd129, 1'b1);
    send_request(OP_READ, 10'd0, 8'd0, 1'b0);        // 127.5 -> 128
    send_request(OP_READ, 10'd1023, 8'd255, 1'b1);   // frame end on read ignored
    send_request(OP_READ, 10'd5, 8'd0, 1'b0);        // 128.5 -> 128
    written_pix = '{0, 1023, 5, 341, 682, 100, 777};
    drain_results();
    write_method(METHOD_MODE);
    send_request(OP_ACC, 10'd7, 8'd3, 1'b0);
    send_request(OP_ACC, 10'd7, 8'd9, 1'b0);
    send_request(OP_ACC, 10'd7, 8'd9, 1'b0);
    send_request(OP_READ, 10'd7, 8'd0, 1'b0);
    send_request(OP_ACC, 10'd7, 8'd3, 1'b0);
    send_request(OP_READ, 10'd7, 8'd0, 1'b0);        // tie -> lowest bin
    send_request(OP_READ, 10'd900, 8'd0, 1'b0);      // empty histogram -> 0
    drain_results();
    write_method(METHOD_MAX);
    send_request(OP_ACC, 10'd5, 8'd200, 1'b0);       // compares low byte of sum
    send_request(OP_READ, 10'd5, 8'd0, 1'b0);
    drain_results();
    write_method(METHOD_MIN);
    send_request(OP_ACC, 10'd5, 8'd10, 1'b0);
    send_request(OP_READ, 10'd5, 8'd0, 1'b0);
  endtask

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Frames of a few samples over a small pixel pool, reads mixed in.
  task automatic run_phase(input logic [1:0] m, input int unsigned n_req);
    logic [9:0]  pool [8];
    logic [9:0]  idx;
    int unsigned sent;
    int unsigned flen;
    logic        fe;
    drain_results();
    write_method(m);
    foreach (pool[i]) pool[i] = 10'($urandom_range(NPIX - 1));
    sent = 0;
    while (sent < n_req) begin
      flen = $urandom_range(10, 1);
      for (int k = 0; k < flen && sent < n_req; k++) begin
        if (m == METHOD_MODE)
          idx = ($urandom_range(3) == 0) ? 10'($urandom_range(NPIX - 1))
                                          : pool[$urandom_range(7)];
        else
          idx = 10'(written_pix[$urandom_range(written_pix.size() - 1)]);
        if ($urandom_range(99) < 25) begin
          send_request(OP_READ, idx, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
          fe = (k == flen - 1) || ($urandom_range(99) < 5);
          send_request(OP_ACC, idx, pick_sample(), fe);
        end
        sent++;
      end
    end
  endtask

  task automatic test_random();
    run_phase(METHOD_MEAN, 260);
    run_phase(METHOD_MODE, 260);
    idle_en = 1'b0;  // one stretch with no stalls on either side
    run_phase(METHOD_MAX, 200);
    idle_en = 1'b1;
    run_phase(METHOD_MIN, 260);
    run_phase(METHOD_MODE, 200);
    run_phase(2'($urandom_range(3)), 180);
    run_phase(METHOD_MEAN, 180);
  endtask

  // Late checks after long mixed use: extremes under max, mean and mode.
  task automatic test_tail();
    drain_results();
    write_method(METHOD_MAX);
    send_request(OP_ACC, 10'd0, 8'd255, 1'b1);
    send_request(OP_ACC, 10'd1023, 8'd0, 1'b0);
    send_request(OP_READ, 10'd0, 8'd0, 1'b0);
    drain_results();
    write_method(METHOD_MEAN);
    send_request(OP_READ, 10'd1023, 8'd0, 1'b0);
    send_request(OP_ACC, 10'd5, 8'd17, 1'b1);
    drain_results();
    write_method(METHOD_MODE);
    send_request(OP_ACC, 10'd300, 8'd1, 1'b0);
    send_request(OP_READ, 10'd300, 8'd0, 1'b0);
  endtask

  initial begin
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_valid_i    <= 1'b0;
    operation_i   <= OP_ACC;
    pixel_index_i <= '0;
    sample_i      <= '0;
    frame_end_i   <= 1'b0;
    out_ready_i   <= 1'b0;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    foreach (shadow_bins[i, j]) shadow_bins[i][j] = '0;
    frames_cnt    = 0;
    method_cfg    = METHOD_MEAN;
    errors        = 0;
    requests_sent = 0;
    results_seen  = 0;
    full_hits     = 0;
    mode_reads    = 0;
    idle_en       = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random();
    test_tail();

    drain_results();
    repeat (300) @(posedge clk_i);  // catch stray results, such as those of slow mode reads
    if (expected_bg.size() != 0) note_mismatch("results missing", 0, expected_bg.size());

    $display("covered: %0d requests, %0d results, all four methods, %0d frames",
             requests_sent, results_seen, frames_cnt);
    $display("covered: %0d mode reads, %0d requests refused with counter full, %0d errors",
             mode_reads, full_hits, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
